// ===== hdl/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared constants, types and codes of the pin touch detector.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int unsigned COLUMNS   = 48;
  localparam int unsigned ROWS      = 24;
  localparam int unsigned WINDOW    = 4;
  localparam int unsigned PIN_COUNT = COLUMNS * ROWS;
  localparam int unsigned ADDR_W    = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
  localparam int unsigned SCAN_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  localparam int unsigned COL_W     = 6;
  localparam int unsigned ROW_W     = 5;
  localparam int unsigned HGT_W     = 8;
  localparam int unsigned DIFF_W    = 9;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 8;
  localparam int unsigned ROW_BITS  = WINDOW * HGT_W;

  localparam logic [HGT_W-1:0]  HIST_RESET = 8'd210;
  localparam logic [HGT_W-1:0]  TOL_RESET  = 8'd2;
  localparam logic [HGT_W-1:0]  THR_RESET  = 8'd21;
  localparam logic [COL_W-1:0]  COL_NONE   = COL_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  ROW_NONE   = ROW_W'(ROWS);
  localparam logic [SCAN_W-1:0] SCAN_LAST  = SCAN_W'(WINDOW - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(PIN_COUNT - 1);
  localparam logic [ADDR_W-1:0] COLUMNS_A  = ADDR_W'(COLUMNS);

  localparam logic [CFG_IDX_W-1:0] CFG_FLAT_TOL  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_THR = CFG_IDX_W'(1);

  typedef logic [WINDOW-1:0][HGT_W-1:0] hist_row_t;

  typedef struct packed {
    logic load;
    logic step;
  } win_ctrl_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_LOAD  = 6'b001000,
    S_SCAN  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

endpackage

// ===== hdl/ptd_ram.sv =====
// ----------------------------------------------------------------------------
// ptd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ptd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ptd_window.sv =====
// ----------------------------------------------------------------------------
// ptd_window
// Window register and shared max/min compare unit, one sample per step.
// ----------------------------------------------------------------------------
module ptd_window import ptd_pkg::*; (
  input  logic             clk_i,
  input  win_ctrl_t        ctrl_i,
  input  hist_row_t        rd_row_i,
  input  logic [HGT_W-1:0] cmd_i,
  output hist_row_t        new_row_o,
  output logic [HGT_W-1:0] spread_o
);

  hist_row_t        win_q, win_d;
  logic [HGT_W-1:0] max_q, max_d;
  logic [HGT_W-1:0] min_q, min_d;

  always_comb begin
    new_row_o[0] = cmd_i;
    for (int k = 1; k < WINDOW; k++) begin
      new_row_o[k] = rd_row_i[k-1];
    end
  end

  always_comb begin
    win_d = win_q;
    max_d = max_q;
    min_d = min_q;
    if (ctrl_i.load) begin
      win_d = new_row_o;
      max_d = '0;
      min_d = '1;
    end else if (ctrl_i.step) begin
      for (int k = 0; k < WINDOW; k++) begin
        win_d[k] = win_q[(k + 1) % WINDOW];
      end
      max_d = (win_q[0] > max_q) ? win_q[0] : max_q;
      min_d = (win_q[0] < min_q) ? win_q[0] : min_q;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    max_q <= max_d;
    min_q <= min_d;
  end

  assign spread_o = max_q - min_q;

endmodule

// ===== hdl/pin_touch_detector_unit.sv =====
// ----------------------------------------------------------------------------
// pin_touch_detector_unit
// Touch detector for an actuated pin display, one pin per transaction.
//
// After reset the block runs a clearing pass over all COLUMNS*ROWS (1152)
// history entries that fills every pin's height history with 210; in_ready_o
// stays low until it ends, while configuration writes are taken at any time.
// Each in-range pin then passes, after acceptance, through a history RAM
// read, a history write-back, each window sample in turn through the shared
// max/min comparator, and the flat and touch decision, which loads the
// output register. The next pin is accepted after that decision. A pin
// outside the grid skips the history and goes straight to the decision.
// The result sits in an output register, so the next pin is accepted
// while it waits; the decision state holds only while that register is
// still full.
// ----------------------------------------------------------------------------
module pin_touch_detector_unit import ptd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DAT_W-1:0]  cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COL_W-1:0]      pin_column_i,
  input  logic [ROW_W-1:0]      pin_row_i,
  input  logic [HGT_W-1:0]      commanded_height_i,
  input  logic [HGT_W-1:0]      measured_height_i,
  input  logic                  frame_end_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  touched_o,
  output logic                  is_flat_o,
  output logic signed [DIFF_W-1:0] height_difference_o,
  output logic                  any_touched_o,
  output logic [COL_W-1:0]      least_touched_column_o,
  output logic [ROW_W-1:0]      least_touched_row_o,
  output logic                  frame_done_o
);

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_cnt_q;
  logic [SCAN_W-1:0]   scan_cnt_q;
  logic [HGT_W-1:0]    tol_q, thr_q;

  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    row_q;
  logic [HGT_W-1:0]    cmd_q;
  logic [DIFF_W-1:0]   diff_q;
  logic [HGT_W-1:0]    mag_q;
  logic                fend_q;
  logic                in_range_q;
  logic [ADDR_W-1:0]   addr_q;

  logic                sum_any_q;
  logic [COL_W-1:0]    sum_col_q;
  logic [ROW_W-1:0]    sum_row_q;

  logic                out_valid_q;
  logic                touched_q, flat_q, any_q, fdone_q;
  logic [DIFF_W-1:0]   odiff_q;
  logic [COL_W-1:0]    ocol_q;
  logic [ROW_W-1:0]    orow_q;

  logic                in_accept;
  logic                out_load;
  logic [DIFF_W-1:0]   diff_in;
  logic [DIFF_W-1:0]   mag_in;
  logic                in_range_in;
  logic                flat_now, touched_now;
  logic                any_next;
  logic [COL_W-1:0]    col_next;
  logic [ROW_W-1:0]    row_next;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ROW_BITS-1:0] ram_wdata, ram_rdata;
  hist_row_t           new_row;
  hist_row_t           reset_row;
  logic [HGT_W-1:0]    spread;
  win_ctrl_t           win_ctrl;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign diff_in     = {1'b0, commanded_height_i} - {1'b0, measured_height_i};
  assign mag_in      = diff_in[DIFF_W-1] ? (~diff_in + DIFF_W'(1)) : diff_in;
  assign in_range_in = ({1'b0, pin_column_i} < (COL_W+1)'(COLUMNS))
                    && ({1'b0, pin_row_i} < (ROW_W+1)'(ROWS));

  assign flat_now    = in_range_q && (spread <= tol_q);
  assign touched_now = flat_now && (mag_q > thr_q);
  assign any_next    = sum_any_q || touched_now;
  assign col_next    = (touched_now && (col_q < sum_col_q)) ? col_q : sum_col_q;
  assign row_next    = (touched_now && (row_q < sum_row_q)) ? row_q : sum_row_q;

  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      reset_row[k] = HIST_RESET;
    end
  end

  assign win_ctrl.load = (state_q == S_LOAD);
  assign win_ctrl.step = (state_q == S_SCAN);

  assign ram_re    = (state_q == S_READ);
  assign ram_we    = (state_q == S_CLEAR) || (state_q == S_LOAD);
  assign ram_waddr = (state_q == S_CLEAR) ? clr_cnt_q : addr_q;
  assign ram_wdata = (state_q == S_CLEAR) ? reset_row : new_row;

  ptd_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (PIN_COUNT)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  ptd_window u_window (
    .clk_i     (clk_i),
    .ctrl_i    (win_ctrl),
    .rd_row_i  (ram_rdata),
    .cmd_i     (cmd_q),
    .new_row_o (new_row),
    .spread_o  (spread)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_cnt_q == ADDR_LAST) state_d = S_IDLE;
      S_IDLE:  if (in_accept) state_d = in_range_in ? S_READ : S_DONE;
      S_READ:  state_d = S_LOAD;
      S_LOAD:  state_d = S_SCAN;
      S_SCAN:  if (scan_cnt_q == SCAN_LAST) state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      scan_cnt_q  <= '0;
      tol_q       <= TOL_RESET;
      thr_q       <= THR_RESET;
      sum_any_q   <= 1'b0;
      sum_col_q   <= COL_NONE;
      sum_row_q   <= ROW_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
      if (state_q == S_LOAD) begin
        scan_cnt_q <= '0;
      end else if (state_q == S_SCAN) begin
        scan_cnt_q <= scan_cnt_q + SCAN_W'(1);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_FLAT_TOL:  tol_q <= cfg_data_i;
          CFG_TOUCH_THR: thr_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        sum_any_q   <= fend_q ? 1'b0     : any_next;
        sum_col_q   <= fend_q ? COL_NONE : col_next;
        sum_row_q   <= fend_q ? ROW_NONE : row_next;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      col_q      <= pin_column_i;
      row_q      <= pin_row_i;
      cmd_q      <= commanded_height_i;
      diff_q     <= diff_in;
      mag_q      <= mag_in[HGT_W-1:0];
      fend_q     <= frame_end_i;
      in_range_q <= in_range_in;
      addr_q     <= ADDR_W'(pin_row_i) * COLUMNS_A + ADDR_W'(pin_column_i);
    end
    if (out_load) begin
      touched_q <= touched_now;
      flat_q    <= flat_now;
      odiff_q   <= diff_q;
      any_q     <= any_next;
      ocol_q    <= col_next;
      orow_q    <= row_next;
      fdone_q   <= fend_q;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign touched_o              = touched_q;
  assign is_flat_o              = flat_q;
  assign height_difference_o    = odiff_q;
  assign any_touched_o          = any_q;
  assign least_touched_column_o = ocol_q;
  assign least_touched_row_o    = orow_q;
  assign frame_done_o           = fdone_q;

endmodule

// ===== hdl/ptd_checker.sv =====
// ----------------------------------------------------------------------------
// ptd_checker
// Port-level checks of the pin touch detector, bound to the top level.
// ----------------------------------------------------------------------------
module ptd_checker import ptd_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  touched_o,
  input logic                  is_flat_o,
  input logic signed [DIFF_W-1:0] height_difference_o,
  input logic                  any_touched_o,
  input logic [COL_W-1:0]      least_touched_column_o,
  input logic [ROW_W-1:0]      least_touched_row_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(height_difference_o)
      && $stable(touched_o) && $stable(least_touched_column_o))
    else $error("stalled result changed");

  a_touch_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && touched_o |-> is_flat_o && any_touched_o)
    else $error("touched pin not flat or not in frame summary");

  a_none_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !any_touched_o |->
      least_touched_column_o == COL_NONE && least_touched_row_o == ROW_NONE)
    else $error("summary holds a pin without any touch");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new transaction taken while a pin is in work");

endmodule

bind pin_touch_detector_unit ptd_checker u_ptd_checker (.*);
